// File: sv/u8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CpW      = 21;
    localparam int unsigned CpBusW   = 24;   // code point padded to whole bytes
    localparam int unsigned PendW    = 2;
    localparam int unsigned PartW    = 15;   // widest partial: 3 + 6 + 6 bits
    localparam int unsigned ContW    = 6;

    // Lead byte prefix masks and matches
    localparam logic [ByteW-1:0] MaskAscii = 8'h80;
    localparam logic [ByteW-1:0] MaskLead2 = 8'hE0;
    localparam logic [ByteW-1:0] CodeLead2 = 8'hC0;
    localparam logic [ByteW-1:0] MaskLead3 = 8'hF0;
    localparam logic [ByteW-1:0] CodeLead3 = 8'hE0;
    localparam logic [ByteW-1:0] MaskLead4 = 8'hF8;
    localparam logic [ByteW-1:0] CodeLead4 = 8'hF0;

    // Payload masks
    localparam logic [ByteW-1:0] PayCont  = 8'h3F;
    localparam logic [ByteW-1:0] PayLead2 = 8'h1F;
    localparam logic [ByteW-1:0] PayLead3 = 8'h0F;
    localparam logic [ByteW-1:0] PayLead4 = 8'h07;

    // Continuation bytes still expected after each lead
    localparam logic [PendW-1:0] PendNone  = 2'd0;
    localparam logic [PendW-1:0] PendLead2 = 2'd1;
    localparam logic [PendW-1:0] PendLead3 = 2'd2;
    localparam logic [PendW-1:0] PendLead4 = 2'd3;

    typedef struct packed {
        logic [PendW-1:0] pending;
        logic [PartW-1:0] partial;
    } t_dec_state;

    typedef struct packed {
        logic           valid;
        logic [CpW-1:0] code_point;
    } t_dec_result;

endpackage

`default_nettype wire

// File: sv/u8d_step.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_step (
    input  wire u8d_pkg::t_dec_state          i_state,
    input  wire logic [u8d_pkg::ByteW-1:0]    i_byte,
    input  wire logic                         i_last,
    output u8d_pkg::t_dec_state               o_state,
    output u8d_pkg::t_dec_result              o_result
);

    logic [u8d_pkg::ContW-1:0] cont_bits;
    logic [u8d_pkg::PendW-1:0] pend_dec;
    u8d_pkg::t_dec_state       nxt;

    assign cont_bits = u8d_pkg::ContW'(i_byte & u8d_pkg::PayCont);
    assign pend_dec  = i_state.pending - u8d_pkg::PendW'(1);

    always_comb begin
        nxt      = i_state;
        o_result = '0;
        if (i_state.pending != u8d_pkg::PendNone) begin
            // take any byte as a continuation, low six bits only
            nxt.pending = pend_dec;
            if (pend_dec == u8d_pkg::PendNone) begin
                o_result.valid      = 1'b1;
                o_result.code_point = {i_state.partial, cont_bits};
                nxt.partial         = '0;
            end else begin
                nxt.partial = {i_state.partial[u8d_pkg::PartW-u8d_pkg::ContW-1:0], cont_bits};
            end
        end else if ((i_byte & u8d_pkg::MaskAscii) == '0) begin
            o_result.valid      = 1'b1;
            o_result.code_point = u8d_pkg::CpW'(i_byte);
        end else if ((i_byte & u8d_pkg::MaskLead2) == u8d_pkg::CodeLead2) begin
            nxt.partial = u8d_pkg::PartW'(i_byte & u8d_pkg::PayLead2);
            nxt.pending = u8d_pkg::PendLead2;
        end else if ((i_byte & u8d_pkg::MaskLead3) == u8d_pkg::CodeLead3) begin
            nxt.partial = u8d_pkg::PartW'(i_byte & u8d_pkg::PayLead3);
            nxt.pending = u8d_pkg::PendLead3;
        end else if ((i_byte & u8d_pkg::MaskLead4) == u8d_pkg::CodeLead4) begin
            nxt.partial = u8d_pkg::PartW'(i_byte & u8d_pkg::PayLead4);
            nxt.pending = u8d_pkg::PendLead4;
        end
        // stray lead bytes fall through: hold state, no result

        // end of text drops any unfinished sequence
        if (i_last) begin
            nxt = '0;
        end
    end

    assign o_state = nxt;

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to code point stream decoder. Feed one text byte per item on the slave
// side, with tlast on the final byte of a text; a 21-bit code point comes out on
// the master side each time a 1 to 4 byte sequence completes. Lead bytes pick
// the length from their top bits, the following bytes are taken as
// continuations without checking, and bytes 0x80-0xBF or 0xF8-0xFF in lead
// position are dropped silently. A sequence cut short by tlast is dropped and
// the decoder starts clean on the next byte; there are no overlong or
// surrogate checks. Throughput is one byte per clock: the decode is a single
// combinational step from the sequence state registers into the output
// register, and a result appears in the cycle after the byte that completes it.
// The slave side stalls only while a finished code point waits in the output
// register and the master side is not ready.

module utf8_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: text bytes
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  wire logic        i_s_tlast,   // end_of_text
    // master side: code points
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // [20:0] code_point, [23:21] zero
);

    u8d_pkg::t_dec_state  r_state;
    u8d_pkg::t_dec_state  n_state;
    u8d_pkg::t_dec_result step_res;

    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [u8d_pkg::CpW-1:0]  r_out_cp;
    logic [u8d_pkg::CpW-1:0]  n_out_cp;
    logic                     in_acc;
    logic                     out_acc;

    // Take a byte whenever the output register is empty or draining this cycle.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_out_valid && i_m_tready;

    u8d_step u_step (
        .i_state  (r_state),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_state  (n_state),
        .o_result (step_res)
    );

    // Load a new result, or drop the delivered one, or hold.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_cp    = r_out_cp;
        if (out_acc) begin
            n_out_valid = 1'b0;
        end
        if (in_acc && step_res.valid) begin
            n_out_valid = 1'b1;
            n_out_cp    = step_res.code_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cp <= n_out_cp;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = u8d_pkg::CpBusW'(r_out_cp);

    // tlast always leaves the decoder with no sequence open
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tlast) |=> (r_state.pending == u8d_pkg::PendNone))
        else $error("sequence state not cleared after last byte");

    // an ASCII byte outside a sequence comes straight out next cycle
    a_ascii_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.pending == u8d_pkg::PendNone && !i_s_tdata[7])
        |=> (o_m_tvalid && o_m_tdata == u8d_pkg::CpBusW'($past(i_s_tdata))))
        else $error("ASCII byte not passed through");

    // a two-byte lead opens a sequence waiting for one continuation
    a_lead2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_s_tlast && r_state.pending == u8d_pkg::PendNone &&
         i_s_tdata[7:5] == 3'b110) |=> (r_state.pending == u8d_pkg::PendLead2))
        else $error("two-byte lead did not set pending count");

    // a delivered result with nothing new behind it empties the output register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !(in_acc && step_res.valid)) |=> !o_m_tvalid)
        else $error("delivered code point repeated");

    // a byte that completes nothing never produces a result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(in_acc && step_res.valid)) |=> !o_m_tvalid)
        else $error("code point invented");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned NumDirected = 25;
    localparam int unsigned RandomItems = 1000;
    localparam int unsigned IdlePct     = 19;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned CycleLimit  = 200000;

    // How the expectation of a directed row is formed
    typedef enum logic [1:0] {
        ROW_PREDICT,   // take it from the decoder model below
        ROW_NO_CP,     // typed: the byte gives no code point
        ROW_CP         // typed: the byte gives the code point in the row
    } t_row_kind;

    typedef struct packed {
        logic [u8d_pkg::ByteW-1:0] text_byte;
        logic                      end_of_text;
        t_row_kind                 kind;
        logic [u8d_pkg::CpW-1:0]   code_point;
    } t_stim_row;

    // Directed text: extremes, each sequence length, stray leads, unchecked
    // continuations, truncation by end of text and completion on the last byte.
    localparam t_stim_row DIRECTED [NumDirected] = '{
        '{8'h00, 1'b0, ROW_CP,      21'h000000},  // lowest ASCII
        '{8'h7F, 1'b0, ROW_CP,      21'h00007F},  // highest ASCII
        '{8'hC2, 1'b0, ROW_PREDICT, 21'h0},       // two-byte form
        '{8'hA9, 1'b0, ROW_PREDICT, 21'h0},
        '{8'hE2, 1'b0, ROW_PREDICT, 21'h0},       // three-byte form
        '{8'h82, 1'b0, ROW_PREDICT, 21'h0},
        '{8'hAC, 1'b0, ROW_PREDICT, 21'h0},
        '{8'hF0, 1'b0, ROW_PREDICT, 21'h0},       // four-byte form
        '{8'h9F, 1'b0, ROW_PREDICT, 21'h0},
        '{8'h98, 1'b0, ROW_PREDICT, 21'h0},
        '{8'h80, 1'b0, ROW_PREDICT, 21'h0},
        '{8'h80, 1'b0, ROW_NO_CP,   21'h0},       // stray continuation as lead
        '{8'hF8, 1'b0, ROW_NO_CP,   21'h0},       // lowest invalid lead
        '{8'hFF, 1'b1, ROW_NO_CP,   21'h0},       // highest byte, ends a text
        '{8'hDF, 1'b0, ROW_PREDICT, 21'h0},       // continuation is not checked
        '{8'h41, 1'b0, ROW_PREDICT, 21'h0},
        '{8'hF7, 1'b0, ROW_PREDICT, 21'h0},       // largest four-byte value
        '{8'hFF, 1'b0, ROW_PREDICT, 21'h0},
        '{8'hFF, 1'b0, ROW_PREDICT, 21'h0},
        '{8'hFF, 1'b0, ROW_CP,      21'h1FFFFF},
        '{8'hE2, 1'b0, ROW_PREDICT, 21'h0},       // cut off by end of text
        '{8'h82, 1'b1, ROW_NO_CP,   21'h0},
        '{8'hF0, 1'b1, ROW_NO_CP,   21'h0},       // lead is the last byte
        '{8'hC3, 1'b0, ROW_PREDICT, 21'h0},       // completes on the last byte
        '{8'hA9, 1'b1, ROW_PREDICT, 21'h0}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [7:0]                   i_s_tdata;     // [7:0] text_byte
    logic                         i_s_tlast;     // end_of_text
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [u8d_pkg::CpBusW-1:0]   o_m_tdata;     // [20:0] code_point, [23:21] zero

    // Decoder model state
    logic [u8d_pkg::PendW-1:0]    cont_left;
    logic [u8d_pkg::CpW-1:0]      cp_gathered;

    logic [u8d_pkg::CpW-1:0]      cp_expected [$];
    logic [u8d_pkg::ByteW-1:0]    text_buf [$];
    int unsigned                  mismatches;
    int unsigned                  bytes_accepted;
    int unsigned                  cycle_count;
    logic                         steady;        // no idling on either side while set

    utf8_stream_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Advance the decoder model by one text byte; flag a finished code point.
    function automatic void decode_text_byte(input logic [u8d_pkg::ByteW-1:0] b,
                                             input logic last,
                                             output logic has_cp,
                                             output logic [u8d_pkg::CpW-1:0] cp);
        has_cp = 1'b0;
        cp     = '0;
        if (cont_left != u8d_pkg::PendNone) begin
            cp_gathered = {cp_gathered[u8d_pkg::CpW-u8d_pkg::ContW-1:0],
                           u8d_pkg::ContW'(b & u8d_pkg::PayCont)};
            cont_left   = cont_left - u8d_pkg::PendW'(1);
            if (cont_left == u8d_pkg::PendNone) begin
                has_cp      = 1'b1;
                cp          = cp_gathered;
                cp_gathered = '0;
            end
        end else if ((b & u8d_pkg::MaskAscii) == '0) begin
            has_cp = 1'b1;
            cp     = u8d_pkg::CpW'(b);
        end else if ((b & u8d_pkg::MaskLead2) == u8d_pkg::CodeLead2) begin
            cp_gathered = u8d_pkg::CpW'(b & u8d_pkg::PayLead2);
            cont_left   = u8d_pkg::PendLead2;
        end else if ((b & u8d_pkg::MaskLead3) == u8d_pkg::CodeLead3) begin
            cp_gathered = u8d_pkg::CpW'(b & u8d_pkg::PayLead3);
            cont_left   = u8d_pkg::PendLead3;
        end else if ((b & u8d_pkg::MaskLead4) == u8d_pkg::CodeLead4) begin
            cp_gathered = u8d_pkg::CpW'(b & u8d_pkg::PayLead4);
            cont_left   = u8d_pkg::PendLead4;
        end
        // any other byte in lead position is skipped
        if (last) begin
            cont_left   = u8d_pkg::PendNone;
            cp_gathered = '0;
        end
    endfunction

    // Offer one byte, idling first at random; on acceptance queue what it yields.
    task automatic send_text_byte(input logic [u8d_pkg::ByteW-1:0] b, input logic last,
                                  input t_row_kind kind,
                                  input logic [u8d_pkg::CpW-1:0] typed_cp);
        logic                    has_cp;
        logic [u8d_pkg::CpW-1:0] cp;
        while (!steady && $urandom_range(0, 99) < IdlePct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_accepted++;
        decode_text_byte(b, last, has_cp, cp);
        case (kind)
            ROW_PREDICT: if (has_cp) cp_expected = {cp_expected, cp};
            ROW_CP:      cp_expected = {cp_expected, typed_cp};
            default:     ;
        endcase
    endtask

    // Build one random text: mostly well-formed sequences with random payload,
    // some loose bytes and some sequences broken short; now and then cut the
    // text off mid-stream.
    task automatic fill_random_text();
        int unsigned               n_chars;
        int unsigned               seq_len;
        int unsigned               n_cont;
        int unsigned               roll;
        int unsigned               cut;
        logic [31:0]               bits;
        logic [u8d_pkg::ByteW-1:0] lead;
        text_buf.delete();
        n_chars = $urandom_range(1, 24);
        for (int unsigned c = 0; c < n_chars; c++) begin
            roll    = $urandom_range(0, 99);
            bits    = $urandom;
            seq_len = (roll < 75) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            case (seq_len)
                1:       lead = {1'b0, bits[6:0]};
                2:       lead = {3'b110, bits[4:0]};
                3:       lead = {4'b1110, bits[3:0]};
                default: lead = {5'b11110, bits[2:0]};
            endcase
            if (roll >= 75 && roll < 90) begin
                text_buf = {text_buf, bits[15:8]};
            end else begin
                n_cont = (roll < 75) ? seq_len - 1 : $urandom_range(0, seq_len - 2);
                text_buf = {text_buf, lead};
                for (int unsigned k = 0; k < n_cont; k++) begin
                    bits = $urandom;
                    text_buf = {text_buf, {2'b10, bits[5:0]}};
                end
            end
        end
        if ($urandom_range(0, 99) < 15 && text_buf.size() > 1) begin
            cut      = $urandom_range(0, text_buf.size() - 2);
            text_buf = text_buf[0:cut];
        end
    endtask

    // Result side: stall at random, check every accepted code point in order.
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cp_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected code point 0x%06h",
                                          o_m_tdata[u8d_pkg::CpW-1:0]));
            end else begin
                if (o_m_tdata[u8d_pkg::CpW-1:0] != cp_expected[0]) begin
                    report_mismatch($sformatf("code point 0x%06h, expected 0x%06h",
                                              o_m_tdata[u8d_pkg::CpW-1:0],
                                              cp_expected[0]));
                end
                if (o_m_tdata[u8d_pkg::CpBusW-1:u8d_pkg::CpW] != '0) begin
                    report_mismatch($sformatf("padding bits 0x%0h are not zero",
                                              o_m_tdata[u8d_pkg::CpBusW-1:u8d_pkg::CpW]));
                end
                cp_expected.delete(0);
            end
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tlast   <= 1'b0;
        i_m_tready  <= 1'b0;
        steady      = 1'b0;
        mismatches  = 0;
        bytes_accepted = 0;
        cont_left   = u8d_pkg::PendNone;
        cp_gathered = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int unsigned r = 0; r < NumDirected; r++) begin
            send_text_byte(DIRECTED[r].text_byte, DIRECTED[r].end_of_text,
                           DIRECTED[r].kind, DIRECTED[r].code_point);
        end

        // Hold off the sender once until every code point so far has drained.
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (cp_expected.size() != 0);

        bytes_accepted = 0;
        while (bytes_accepted < RandomItems) begin
            steady = (bytes_accepted >= 400 && bytes_accepted < 600);
            fill_random_text();
            foreach (text_buf[k]) begin
                send_text_byte(text_buf[k], k == text_buf.size() - 1, ROW_PREDICT, '0);
            end
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;

        while (cp_expected.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (cp_expected.size() != 0) begin
            report_mismatch($sformatf("%0d code points never came", cp_expected.size()));
        end

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
